// ===== hw/rtl/rsc_pkg.sv =====
// RPN stack calculator: shared constants, types and the microcode table.
// Depends on nothing; used by the interfaces, the top level, the divider and the checker.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam int Q_W    = 32;
  localparam int OPC_W  = 3;
  localparam int ST_W   = 2;
  localparam int DIVN_W = Q_W + 16;
  localparam int DIVC_W = $clog2(DIVN_W + 1);
  localparam int PC_W   = 4;

  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  localparam logic [OPC_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OPC_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OPC_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OPC_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OPC_W-1:0] OP_DIV  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_DIVZERO = 2'd2;
  localparam logic [ST_W-1:0] ST_SAT     = 2'd3;

  // microcode step addresses
  localparam logic [PC_W-1:0] PC_FETCH   = 4'd0;
  localparam logic [PC_W-1:0] PC_PUSH    = 4'd1;
  localparam logic [PC_W-1:0] PC_POPR    = 4'd2;
  localparam logic [PC_W-1:0] PC_POPL    = 4'd3;
  localparam logic [PC_W-1:0] PC_LATL    = 4'd4;
  localparam logic [PC_W-1:0] PC_EXEC    = 4'd5;
  localparam logic [PC_W-1:0] PC_DIV     = 4'd6;
  localparam logic [PC_W-1:0] PC_DIVFIN  = 4'd7;
  localparam logic [PC_W-1:0] PC_MULFIN  = 4'd8;
  localparam logic [PC_W-1:0] PC_PUSHRES = 4'd9;
  localparam logic [PC_W-1:0] PC_RDTOP   = 4'd10;
  localparam logic [PC_W-1:0] PC_EMIT    = 4'd11;

  typedef enum logic [3:0] {
    A_FETCH, A_PUSH, A_POPR, A_POPL, A_LATL, A_EXEC,
    A_DIV, A_DIVFIN, A_MULFIN, A_PUSHRES, A_RDTOP, A_EMIT
  } act_t;

  typedef enum logic [2:0] {
    SQ_NEXT, SQ_GOTO, SQ_DISPATCH, SQ_OPSEL, SQ_LOOP, SQ_WAITOUT
  } seq_t;

  typedef struct packed {
    act_t            act;
    seq_t            seq;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic [Q_W-1:0] value;
    logic           sat;
  } sat_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{act: A_FETCH, seq: SQ_GOTO, target: PC_FETCH};
    case (pc)
      PC_FETCH:   w = '{act: A_FETCH,   seq: SQ_DISPATCH, target: PC_FETCH};
      PC_PUSH:    w = '{act: A_PUSH,    seq: SQ_GOTO,     target: PC_RDTOP};
      PC_POPR:    w = '{act: A_POPR,    seq: SQ_NEXT,     target: PC_FETCH};
      PC_POPL:    w = '{act: A_POPL,    seq: SQ_NEXT,     target: PC_FETCH};
      PC_LATL:    w = '{act: A_LATL,    seq: SQ_NEXT,     target: PC_FETCH};
      PC_EXEC:    w = '{act: A_EXEC,    seq: SQ_OPSEL,    target: PC_FETCH};
      PC_DIV:     w = '{act: A_DIV,     seq: SQ_LOOP,     target: PC_DIVFIN};
      PC_DIVFIN:  w = '{act: A_DIVFIN,  seq: SQ_GOTO,     target: PC_PUSHRES};
      PC_MULFIN:  w = '{act: A_MULFIN,  seq: SQ_NEXT,     target: PC_FETCH};
      PC_PUSHRES: w = '{act: A_PUSHRES, seq: SQ_NEXT,     target: PC_FETCH};
      PC_RDTOP:   w = '{act: A_RDTOP,   seq: SQ_NEXT,     target: PC_FETCH};
      PC_EMIT:    w = '{act: A_EMIT,    seq: SQ_WAITOUT,  target: PC_FETCH};
      default:    w = '{act: A_FETCH,   seq: SQ_GOTO,     target: PC_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [Q_W-1:0] mag(input logic [Q_W-1:0] x);
    return x[Q_W-1] ? (~x + 1'b1) : x;
  endfunction

  // Clamp a sign and magnitude pair to the Q16.16 range.
  function automatic sat_t sat_mag(input logic neg, input logic [DIVN_W-1:0] m);
    sat_t s;
    s.sat   = 1'b0;
    s.value = m[Q_W-1:0];
    if (neg) begin
      if (m > DIVN_W'(Q_MIN)) begin
        s.value = Q_MIN;
        s.sat   = 1'b1;
      end else begin
        s.value = ~m[Q_W-1:0] + 1'b1;
      end
    end else if (m > DIVN_W'(Q_MAX)) begin
      s.value = Q_MAX;
      s.sat   = 1'b1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rsc_if.sv =====
// Valid/ready channel interfaces for the RPN stack calculator.
// Depends on rsc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rsc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [rsc_pkg::OPC_W-1:0]           opcode;
  logic signed [rsc_pkg::Q_W-1:0]      operand_value;

  modport source (output valid, output opcode, output operand_value, input ready);
  modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

interface rsc_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [rsc_pkg::Q_W-1:0]      top_value;
  logic [rsc_pkg::ST_W-1:0]            status;

  modport source (output valid, output top_value, output status, input ready);
  modport sink   (input valid, input top_value, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rpn_stack_calculator_unit.sv =====
// RPN stack calculator top level: microcode sequencer, operand stack and datapath.
// Depends on rsc_pkg, rsc_cmd_if, rsc_res_if and rsc_divider.
// Each accepted transaction runs its own microcode path: push, unused opcode, add/subtract,
// multiply and divide (which waits on the one-bit-per-cycle divider) differ in length.
// One transaction at a time; the next is taken once the result is registered.
// Synchronous reset empties the stack and drops any pending result; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rpn_stack_calculator_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  rsc_cmd_if.sink    cmd,
  rsc_res_if.source  res
);

  localparam int QW = rsc_pkg::Q_W;

  logic [rsc_pkg::PC_W-1:0]   pc;
  logic [rsc_pkg::PC_W-1:0]   pc_next;
  rsc_pkg::uword_t            uw;

  logic [rsc_pkg::CNT_W-1:0]  count;
  logic [rsc_pkg::CNT_W-1:0]  cnt_m1;
  logic                       full;
  logic                       empty;

  logic [QW-1:0]              mem [rsc_pkg::STACK_DEPTH];
  logic [QW-1:0]              rdata;
  logic                       mem_we;
  logic                       mem_re;
  logic [rsc_pkg::ADDR_W-1:0] waddr;
  logic [rsc_pkg::ADDR_W-1:0] raddr;
  logic [QW-1:0]              wdata;

  logic [rsc_pkg::OPC_W-1:0]  op;
  logic [QW-1:0]              val;
  logic [QW-1:0]              right;
  logic [QW-1:0]              left;
  logic                       right_ok;
  logic                       left_ok;
  logic                       neg;
  logic                       dz;
  logic [2*QW-1:0]            prod;
  logic [QW-1:0]              result;
  logic [rsc_pkg::ST_W-1:0]   status;

  logic [QW:0]                sum;
  logic [QW:0]                diff;
  rsc_pkg::sat_t              mul_s;
  rsc_pkg::sat_t              div_s;

  logic                       div_load;
  logic                       div_busy;
  logic [rsc_pkg::DIVN_W-1:0] quotient;

  logic                       out_valid;
  logic [QW-1:0]              out_top;
  logic [rsc_pkg::ST_W-1:0]   out_status;
  logic                       accept;
  logic                       emit_go;

  assign uw      = rsc_pkg::ucode(pc);
  assign full    = count == rsc_pkg::CNT_W'(rsc_pkg::STACK_DEPTH);
  assign empty   = count == '0;
  assign cnt_m1  = count - 1'b1;
  assign accept  = cmd.valid && cmd.ready;
  assign emit_go = !out_valid || res.ready;

  assign cmd.ready     = uw.act == rsc_pkg::A_FETCH;
  assign res.valid     = out_valid;
  assign res.top_value = out_top;
  assign res.status    = out_status;

  // sequencer
  always_comb begin
    pc_next = pc;
    case (uw.seq)
      rsc_pkg::SQ_NEXT: pc_next = pc + 1'b1;
      rsc_pkg::SQ_GOTO: pc_next = uw.target;
      rsc_pkg::SQ_DISPATCH: begin
        if (accept) begin
          if (cmd.opcode == rsc_pkg::OP_PUSH) begin
            pc_next = rsc_pkg::PC_PUSH;
          end else if (cmd.opcode inside {[rsc_pkg::OP_ADD:rsc_pkg::OP_DIV]}) begin
            pc_next = rsc_pkg::PC_POPR;
          end else begin
            pc_next = rsc_pkg::PC_RDTOP;
          end
        end
      end
      rsc_pkg::SQ_OPSEL: begin
        case (op)
          rsc_pkg::OP_DIV: pc_next = rsc_pkg::PC_DIV;
          rsc_pkg::OP_MUL: pc_next = rsc_pkg::PC_MULFIN;
          default:         pc_next = rsc_pkg::PC_PUSHRES;
        endcase
      end
      rsc_pkg::SQ_LOOP:    pc_next = div_busy ? pc : uw.target;
      rsc_pkg::SQ_WAITOUT: pc_next = emit_go ? uw.target : pc;
      default:             pc_next = rsc_pkg::PC_FETCH;
    endcase
  end

  // stack memory control
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    wdata  = result;
    case (uw.act)
      rsc_pkg::A_PUSH: begin
        mem_we = !full;
        wdata  = val;
      end
      rsc_pkg::A_PUSHRES: mem_we = !full;
      rsc_pkg::A_POPR, rsc_pkg::A_POPL, rsc_pkg::A_RDTOP: mem_re = !empty;
      default: ;
    endcase
  end

  assign waddr = count[rsc_pkg::ADDR_W-1:0];
  assign raddr = cnt_m1[rsc_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  // arithmetic
  assign sum   = {left[QW-1], left} + {right[QW-1], right};
  assign diff  = {left[QW-1], left} - {right[QW-1], right};
  assign mul_s = rsc_pkg::sat_mag(neg, prod[2*QW-1:16]);
  assign div_s = rsc_pkg::sat_mag(neg, quotient);

  assign div_load = uw.act == rsc_pkg::A_EXEC && op == rsc_pkg::OP_DIV;

  rsc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend ({rsc_pkg::mag(left), 16'b0}),
    .divisor  (rsc_pkg::mag(right)),
    .quotient (quotient),
    .busy     (div_busy)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= rsc_pkg::PC_FETCH;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      case (uw.act)
        rsc_pkg::A_PUSH, rsc_pkg::A_PUSHRES: begin
          if (!full) begin
            count <= count + 1'b1;
          end
        end
        rsc_pkg::A_POPR, rsc_pkg::A_POPL: begin
          if (!empty) begin
            count <= cnt_m1;
          end
        end
        default: ;
      endcase
      if (uw.act == rsc_pkg::A_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (uw.act)
      rsc_pkg::A_FETCH: begin
        if (accept) begin
          op     <= cmd.opcode;
          val    <= cmd.operand_value;
          status <= rsc_pkg::ST_OK;
        end
      end
      rsc_pkg::A_PUSH: begin
        if (full) begin
          status <= rsc_pkg::ST_FULL;
        end
      end
      rsc_pkg::A_POPR: right_ok <= !empty;
      rsc_pkg::A_POPL: begin
        right   <= right_ok ? rdata : '0;
        left_ok <= !empty;
      end
      rsc_pkg::A_LATL: left <= left_ok ? rdata : '0;
      rsc_pkg::A_EXEC: begin
        neg  <= left[QW-1] ^ right[QW-1];
        dz   <= right == '0;
        prod <= rsc_pkg::mag(left) * rsc_pkg::mag(right);
        case (op)
          rsc_pkg::OP_ADD: begin
            if (sum[QW] != sum[QW-1]) begin
              result <= sum[QW] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
              status <= rsc_pkg::ST_SAT;
            end else begin
              result <= sum[QW-1:0];
            end
          end
          rsc_pkg::OP_SUB: begin
            if (diff[QW] != diff[QW-1]) begin
              result <= diff[QW] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
              status <= rsc_pkg::ST_SAT;
            end else begin
              result <= diff[QW-1:0];
            end
          end
          default: ;
        endcase
      end
      rsc_pkg::A_MULFIN: begin
        result <= mul_s.value;
        if (mul_s.sat) begin
          status <= rsc_pkg::ST_SAT;
        end
      end
      rsc_pkg::A_DIVFIN: begin
        if (dz) begin
          result <= left[QW-1] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
          status <= rsc_pkg::ST_DIVZERO;
        end else begin
          result <= div_s.value;
          if (div_s.sat) begin
            status <= rsc_pkg::ST_SAT;
          end
        end
      end
      rsc_pkg::A_EMIT: begin
        if (emit_go) begin
          out_top    <= empty ? '0 : rdata;
          out_status <= status;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rsc_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the Q16.16 divide.
// Depends on rsc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module rsc_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire logic [rsc_pkg::DIVN_W-1:0]   dividend,
  input  wire logic [rsc_pkg::Q_W-1:0]      divisor,
  output logic [rsc_pkg::DIVN_W-1:0]        quotient,
  output logic                              busy
);

  logic [rsc_pkg::Q_W-1:0]    rem;
  logic [rsc_pkg::Q_W-1:0]    dsr;
  logic [rsc_pkg::DIVN_W-1:0] quo;
  logic [rsc_pkg::DIVC_W-1:0] cnt;
  logic [rsc_pkg::Q_W:0]      trial;
  logic                       fits;

  assign trial    = {rem, quo[rsc_pkg::DIVN_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign busy     = cnt != '0;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= rsc_pkg::DIVC_W'(rsc_pkg::DIVN_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      // shift the next dividend bit in, subtract where the divisor fits
      rem <= fits ? rsc_pkg::Q_W'(trial - {1'b0, dsr}) : trial[rsc_pkg::Q_W-1:0];
      quo <= {quo[rsc_pkg::DIVN_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rsc_checker.sv =====
// Port-level checks for the RPN stack calculator, bound to the top level.
// Depends on rsc_pkg and rpn_stack_calculator_unit.
`timescale 1ns / 1ps
`default_nettype none

module rsc_port_checks (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        cmd_valid,
  input wire logic                        cmd_ready,
  input wire logic                        res_valid,
  input wire logic                        res_ready,
  input wire logic [rsc_pkg::Q_W-1:0]     res_top_value,
  input wire logic [rsc_pkg::ST_W-1:0]    res_status
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_top_value) && $stable(res_status))
    else $error("stalled result changed");

  // reset drops any pending result
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // one transaction at a time: the sequencer leaves the fetch step
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("input taken twice in a row");

  // a result never follows its transaction in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !$rose(res_valid))
    else $error("result too early");

  // divide by zero always leaves a saturated value on top
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == rsc_pkg::ST_DIVZERO |->
      res_top_value == rsc_pkg::Q_MAX || res_top_value == rsc_pkg::Q_MIN)
    else $error("divide by zero without saturated value");

endmodule

bind rpn_stack_calculator_unit rsc_port_checks u_rsc_port_checks (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_top_value (res.top_value),
  .res_status    (res.status)
);

`default_nettype wire

// ===== bench/rsc_checker.sv =====
// Scoreboard for the RPN stack calculator: watches both channels, predicts each result.
// Depends on rsc_pkg, rsc_cmd_if and rsc_res_if.
`timescale 1ns / 1ps

module rsc_checker
  import rsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rsc_cmd_if   cmd,
  rsc_res_if   res,
  output int   fail_count,
  output int   pending
);

  localparam int MAX_REPORTS = 100;
  localparam logic signed [63:0] WIDE_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] WIDE_LO = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [Q_W-1:0]  top_value;
    logic [ST_W-1:0] status;
  } calc_result_t;

  logic [Q_W-1:0] calc_stack [STACK_DEPTH];
  int             calc_depth;
  calc_result_t   due_results [$];
  int             reports;

  function automatic logic signed [63:0] pop_operand();
    if (calc_depth == 0) return '0;
    calc_depth--;
    return $signed(calc_stack[calc_depth]);
  endfunction

  function automatic logic [63:0] abs_wide(input logic signed [63:0] x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic sat_t clamp_wide(input logic signed [63:0] x);
    sat_t s;
    s.sat   = 1'b0;
    s.value = x[Q_W-1:0];
    if (x > WIDE_HI) begin
      s.sat   = 1'b1;
      s.value = Q_MAX;
    end else if (x < WIDE_LO) begin
      s.sat   = 1'b1;
      s.value = Q_MIN;
    end
    return s;
  endfunction

  function automatic sat_t signmag_to_q(input logic neg, input logic [63:0] m);
    sat_t s;
    s.sat = 1'b0;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        s.sat   = 1'b1;
        s.value = Q_MIN;
      end else begin
        s.value = ~m[Q_W-1:0] + 1'b1;
      end
    end else if (m > 64'h7FFF_FFFF) begin
      s.sat   = 1'b1;
      s.value = Q_MAX;
    end else begin
      s.value = m[Q_W-1:0];
    end
    return s;
  endfunction

  // Advance the stack by one command and return the result it should produce.
  function automatic calc_result_t predict_result(input logic [OPC_W-1:0] op,
                                                  input logic [Q_W-1:0] val);
    calc_result_t       r;
    logic signed [63:0] rhs;
    logic signed [63:0] lhs;
    logic               neg;
    sat_t               s;
    r.status = ST_OK;
    s.sat    = 1'b0;
    s.value  = '0;
    case (op)
      OP_PUSH: begin
        if (calc_depth >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          calc_stack[calc_depth] = val;
          calc_depth++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        rhs = pop_operand();
        lhs = pop_operand();
        neg = (lhs < 0) != (rhs < 0);
        case (op)
          OP_ADD: s = clamp_wide(lhs + rhs);
          OP_SUB: s = clamp_wide(lhs - rhs);
          OP_MUL: s = signmag_to_q(neg, (abs_wide(lhs) * abs_wide(rhs)) >> 16);
          default: begin
            if (rhs == 0) begin
              s.value  = (lhs < 0) ? Q_MIN : Q_MAX;
              r.status = ST_DIVZERO;
            end else begin
              s = signmag_to_q(neg, (abs_wide(lhs) << 16) / abs_wide(rhs));
            end
          end
        endcase
        if (s.sat && r.status == ST_OK) r.status = ST_SAT;
        if (calc_depth < STACK_DEPTH) begin
          calc_stack[calc_depth] = s.value;
          calc_depth++;
        end
      end
      default: ;
    endcase
    r.top_value = (calc_depth == 0) ? '0 : calc_stack[calc_depth - 1];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    reports    = 0;
    calc_depth = 0;
  end

  always @(posedge clk) begin
    calc_result_t want;
    if (rst) begin
      calc_depth = 0;
      due_results.delete();
    end else begin
      if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
        due_results.push_back(predict_result(cmd.opcode, cmd.operand_value));
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        if (due_results.size() == 0) begin
          fail_count++;
          if (reports < MAX_REPORTS)
            $display("%0t checker: unexpected result, expected none, actual top %h status %0d",
                     $time, res.top_value, res.status);
          reports++;
        end else begin
          want = due_results.pop_front();
          if (res.top_value !== want.top_value) begin
            fail_count++;
            if (reports < MAX_REPORTS)
              $display("%0t checker: top_value expected %h, actual %h",
                       $time, want.top_value, res.top_value);
            reports++;
          end
          if (res.status !== want.status) begin
            fail_count++;
            if (reports < MAX_REPORTS)
              $display("%0t checker: status expected %0d, actual %0d",
                       $time, want.status, res.status);
            reports++;
          end
        end
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== bench/tb_rpn_stack_calculator_unit.sv =====
// Testbench top for the RPN stack calculator: clock, reset, command and result drivers.
// Depends on rsc_pkg, the channel interfaces, the calculator top level and rsc_checker.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator_unit;
  import rsc_pkg::*;

  localparam logic [OPC_W-1:0] OP_SPARE_LO = OP_DIV + 1'b1;
  localparam logic [OPC_W-1:0] OP_SPARE_HI = '1;

  localparam int TOTAL_ITEMS = 750;
  localparam int HOLD_AT     = 300;
  localparam int LONG_HOLD   = 200;
  localparam int PAUSE_AT    = 400;
  localparam int DRAIN       = 80;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   items_sent    = 0;
  int   results_taken = 0;
  int   cycle_count   = 0;

  rsc_cmd_if cmd_ch ();
  rsc_res_if res_ch ();

  rpn_stack_calculator_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  rsc_checker result_check (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly modest magnitudes so multiply and divide do not always saturate.
  function automatic logic [Q_W-1:0] pick_value();
    logic [Q_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = Q_MAX;
      1:       v = Q_MIN;
      2:       v = '0;
      3, 4:    v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h00FF_FFFF);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [OPC_W-1:0] op, input logic [Q_W-1:0] val);
    int gap;
    gap = ((items_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.opcode        <= op;
    cmd_ch.operand_value <= val;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    items_sent++;
    @(negedge clk);
  endtask

  // Result side: random back-pressure, one long hold to stall the input.
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_taken == HOLD_AT) gap = LONG_HOLD;
      else if ((results_taken / 50) % 4 == 3) gap = 0;
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      results_taken++;
      @(negedge clk);
    end
  end

  initial begin
    int  kind;
    int  n;
    int  k;
    bit  paused;
    paused = 1'b0;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.opcode        <= OP_PUSH;
    cmd_ch.operand_value <= '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: empty reads, missing operands, saturation and divide by zero
    send_item(OP_SPARE_HI, $urandom);
    send_item(OP_ADD, $urandom);
    send_item(OP_DIV, $urandom);
    send_item(OP_PUSH, Q_MAX);
    send_item(OP_ADD, $urandom);
    send_item(OP_PUSH, Q_MIN);
    send_item(OP_SUB, $urandom);
    send_item(OP_PUSH, Q_MIN);
    send_item(OP_MUL, $urandom);
    send_item(OP_PUSH, '0);
    send_item(OP_DIV, $urandom);
    send_item(OP_PUSH, '1);
    send_item(OP_DIV, $urandom);
    send_item(OP_SUB, $urandom);
    send_item(OP_SPARE_LO, $urandom);
    send_item(OP_SPARE_LO + 1'b1, $urandom);
    send_item(OP_PUSH, 32'h0001_8000);
    send_item(OP_PUSH, 32'hFFFF_4000);
    send_item(OP_MUL, $urandom);

    while (items_sent < TOTAL_ITEMS) begin
      if (!paused && items_sent >= PAUSE_AT) begin
        // hold the sender until every result is back
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        paused = 1'b1;
      end
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        n = $urandom_range(2, 5);
        for (k = 0; k < n; k++) send_item(OP_PUSH, pick_value());
        n = n - 1 + $urandom_range(0, 1);
        for (k = 0; k < n; k++)
          send_item(OPC_W'($urandom_range(OP_ADD, OP_DIV)), $urandom);
      end else if (kind < 16) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          send_item(OPC_W'($urandom_range(OP_PUSH, OP_SPARE_HI)), $urandom);
      end else if (kind < 18) begin
        // operators ahead of their operands
        for (k = 0; k < 2; k++)
          send_item(OPC_W'($urandom_range(OP_ADD, OP_DIV)), $urandom);
        send_item(OP_PUSH, pick_value());
      end else begin
        // overfill the stack, then fold a little back
        for (k = 0; k < STACK_DEPTH + 2; k++) send_item(OP_PUSH, pick_value());
        for (k = 0; k < 2; k++)
          send_item(OPC_W'($urandom_range(OP_ADD, OP_DIV)), $urandom);
      end
    end

    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rsc_pkg.sv
hw/rtl/rsc_if.sv
hw/rtl/rsc_divider.sv
hw/rtl/rpn_stack_calculator_unit.sv
hw/rtl/rsc_checker.sv
bench/rsc_checker.sv
bench/tb_rpn_stack_calculator_unit.sv
